// ----- hw/rtl/dbfs_pkg.sv -----
// shared types and constants for the duplex bus frame splitter
// no dependencies

package dbfs_pkg;

  localparam logic [7:0] IDLE_A   = 8'hFF;
  localparam logic [7:0] IDLE_B   = 8'hEE;
  localparam logic [7:0] SUM_OK   = 8'hFF;
  localparam logic [7:0] MIN_LEN  = 8'd4;
  localparam logic [7:0] MIN_MARK = 8'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CSUM  = 2'd1,
    ST_SHORT = 2'd2
  } frame_status_t;

  typedef struct packed {
    logic [7:0]    byte_value;
    logic          from_response;
    logic          byte_stored;
    logic [7:0]    byte_index;
    logic          frame_done;
    frame_status_t frame_status;
    logic [7:0]    frame_length;
    logic [7:0]    response_start;
  } result_t;

  function automatic logic is_idle(input logic [7:0] b);
    return (b == IDLE_A) || (b == IDLE_B);
  endfunction

endpackage

// ----- hw/rtl/dbfs_in_reg.sv -----
// input register for one byte pair beat
// no package dependencies

module dbfs_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_cmd_byte,
  input  logic [7:0] in_rsp_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_cmd,
  output logic [7:0] held_rsp
);

  logic       valid_r;
  logic [7:0] cmd_r;
  logic [7:0] rsp_r;
  logic       load;

  assign in_stall   = valid_r && !take;
  assign load       = in_valid && !in_stall;
  assign held_valid = valid_r;
  assign held_cmd   = cmd_r;
  assign held_rsp   = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= in_cmd_byte;
      rsp_r <= in_rsp_byte;
    end
  end

endmodule

// ----- hw/rtl/dbfs_core.sv -----
// frame state and per-beat direction, checksum and close logic
// depends on dbfs_pkg

module dbfs_core #(
  parameter int MAX_FRAME = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [7:0]         cmd_byte,
  input  logic [7:0]         rsp_byte,
  output dbfs_pkg::result_t  res
);

  localparam logic [7:0] MaxCnt = MAX_FRAME[7:0];

  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] mark_r, mark_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       good_r, good_nxt;

  logic [7:0] cnt_base;
  logic [7:0] sum_base;
  logic       sum_bad;

  assign sum_bad = (sum_r != dbfs_pkg::SUM_OK);

  always_comb begin
    res      = '0;
    cnt_base = cnt_r;
    sum_base = sum_r;
    mark_nxt = mark_r;
    good_nxt = good_r;
    if (!dbfs_pkg::is_idle(cmd_byte)) begin
      if (mark_r != 8'd0) begin
        res.frame_done     = 1'b1;
        res.frame_length   = cnt_r;
        res.response_start = mark_r;
        if (cnt_r < dbfs_pkg::MIN_LEN || mark_r < dbfs_pkg::MIN_MARK) begin
          res.frame_status = dbfs_pkg::ST_SHORT;
        end else if (!good_r || sum_bad) begin
          res.frame_status = dbfs_pkg::ST_CSUM;
        end else begin
          res.frame_status = dbfs_pkg::ST_OK;
        end
        cnt_base = 8'd0;
        mark_nxt = 8'd0;
        sum_base = 8'd0;
        good_nxt = 1'b1;
      end
      res.byte_value    = cmd_byte;
      res.from_response = 1'b0;
    end else if (!dbfs_pkg::is_idle(rsp_byte)) begin
      if (mark_r == 8'd0) begin
        good_nxt = good_r && !sum_bad;
        mark_nxt = cnt_r;
        sum_base = 8'd0;
      end
      res.byte_value    = rsp_byte;
      res.from_response = 1'b1;
    end else begin
      res.byte_value    = dbfs_pkg::IDLE_A;
      res.from_response = (mark_r != 8'd0);
    end
    sum_nxt = sum_base + res.byte_value;
    cnt_nxt = cnt_base;
    if (cnt_base < MaxCnt) begin
      res.byte_stored = 1'b1;
      res.byte_index  = cnt_base;
      cnt_nxt         = cnt_base + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 8'd0;
      mark_r <= 8'd0;
      sum_r  <= 8'd0;
      good_r <= 1'b1;
    end else if (take) begin
      cnt_r  <= cnt_nxt;
      mark_r <= mark_nxt;
      sum_r  <= sum_nxt;
      good_r <= good_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MaxCnt)
    else $error("frame count beyond limit");

  a_mark_below_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    mark_r <= cnt_r)
    else $error("response mark beyond frame count");

  a_close_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    take && res.frame_done |=> cnt_r == 8'd1 && mark_r == 8'd0)
    else $error("closed frame did not restart");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    take && !res.byte_stored |-> cnt_r == MaxCnt && !res.frame_done)
    else $error("byte dropped while frame had room");

endmodule

// ----- hw/rtl/duplex_bus_frame_splitter_top.sv -----
// top level: input register, frame core and result register
// depends on dbfs_pkg, dbfs_in_reg, dbfs_core
// an accepted beat passes the input register and then the result register before its result shows on the outputs
// throughput: one beat per cycle while out_stall is low, the result register takes a beat whenever empty or drained
// in_stall rises only while both the input and result registers hold unclaimed beats
// reset (rst_n low, synchronous) empties both registers and clears the frame state

module duplex_bus_frame_splitter_top #(
  parameter int MAX_FRAME = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_cmd_byte,
  input  logic [7:0] in_rsp_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte_value,
  output logic       out_from_response,
  output logic       out_byte_stored,
  output logic [7:0] out_byte_index,
  output logic       out_frame_done,
  output logic [1:0] out_frame_status,
  output logic [7:0] out_frame_length,
  output logic [7:0] out_response_start
);

  logic              held_valid;
  logic [7:0]        held_cmd;
  logic [7:0]        held_rsp;
  logic              take;
  dbfs_pkg::result_t res;
  dbfs_pkg::result_t res_r;
  logic              out_valid_r;

  assign take = held_valid && (!out_valid_r || !out_stall);

  dbfs_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd_byte(in_cmd_byte),
    .in_rsp_byte(in_rsp_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_cmd   (held_cmd),
    .held_rsp   (held_rsp)
  );

  dbfs_core #(
    .MAX_FRAME(MAX_FRAME)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .cmd_byte(held_cmd),
    .rsp_byte(held_rsp),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte_value     = res_r.byte_value;
  assign out_from_response  = res_r.from_response;
  assign out_byte_stored    = res_r.byte_stored;
  assign out_byte_index     = res_r.byte_index;
  assign out_frame_done     = res_r.frame_done;
  assign out_frame_status   = res_r.frame_status;
  assign out_frame_length   = res_r.frame_length;
  assign out_response_start = res_r.response_start;

endmodule
